@@ design/crcd_pkg.sv @@
// Shared types, constants and functions for the CRC-checked record deframer.
package crcd_pkg;

    localparam int POS_W      = 7;
    localparam int SEQ_END    = 8;
    localparam int TS_END     = 16;
    localparam int LEN_END    = 20;
    localparam int CRC_END    = 24;
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_DEPTH = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [47:0] MAX48    = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_LEN_ERR = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  payload_byte;
        logic        last_of_run;
        logic [63:0] sequence_res;
        logic [63:0] timestamp;
        logic [31:0] good_records;
        logic [31:0] failed_records;
        logic [47:0] bytes_accepted;
    } t_result;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] sequence_res;
        logic [63:0] timestamp;
        logic [31:0] good_records;
        logic [31:0] failed_records;
        logic [47:0] bytes_accepted;
        logic        bank;
    } t_cmd;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

@@ design/crcd_cmd_queue.sv @@
// Two-entry command queue between the record parser and the result sequencer.
module crcd_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  crcd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output crcd_pkg::t_cmd o_head,
    output logic          o_valid,
    output logic          o_full
);
    import crcd_pkg::*;

    t_cmd                 r_entry [0:CMDQ_DEPTH-1];
    logic [CMDQ_AW-1:0]   r_wr_ptr;
    logic [CMDQ_AW-1:0]   r_rd_ptr;
    logic [CMDQ_AW:0]     r_count;

    assign o_head  = r_entry[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (CMDQ_AW+1)'(CMDQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (CMDQ_AW+1)'(i_push) - (CMDQ_AW+1)'(i_pop);
        end
    end

endmodule

@@ design/crcd_front.sv @@
// Record parser: header capture, CRC accumulation, payload write and command issue.
module crcd_front #(
    parameter int PAYLOAD_BYTES = 32,
    parameter int HEADER_BYTES  = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  crcd_pkg::t_in_item    i_item,
    input  logic                  i_q_full,
    input  logic                  i_release,
    output logic                  o_full,
    output logic                  o_q_push,
    output crcd_pkg::t_cmd        o_cmd,
    output logic                  o_wr_en,
    output logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1):0] o_wr_addr,
    output logic [7:0]            o_wr_data
);
    import crcd_pkg::*;

    localparam int IDX_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int REC_BYTES = HEADER_BYTES + PAYLOAD_BYTES;

    logic [POS_W-1:0] r_pos,     n_pos;
    logic             r_halted,  n_halted;
    logic [63:0]      r_seq,     n_seq;
    logic [63:0]      r_ts,      n_ts;
    logic [31:0]      r_len,     n_len;
    logic [31:0]      r_exp,     n_exp;
    logic [31:0]      r_crc,     n_crc;
    logic [31:0]      r_good,    n_good;
    logic [31:0]      r_fail,    n_fail;
    logic [47:0]      r_bytes,   n_bytes;
    logic             r_wbank,   n_wbank;
    logic [1:0]       r_busy,    n_busy;

    logic             accept;
    logic             in_payload;
    logic [POS_W-1:0] np;
    logic             len_err;
    logic             push_good;
    logic [1:0]       cmd_status;
    logic [48:0]      bytes_sum;

    assign in_payload = !r_halted && (r_pos >= POS_W'(HEADER_BYTES));
    assign o_full     = i_q_full || (in_payload && (r_busy == 2'd2));
    assign accept     = i_push && !o_full;
    assign np         = r_pos + 1'b1;
    assign bytes_sum  = {1'b0, r_bytes} + 49'(REC_BYTES);

    assign o_wr_data  = i_item.data_byte;
    assign o_wr_addr  = {r_wbank, IDX_W'(r_pos - POS_W'(HEADER_BYTES))};

    always_comb begin
        n_pos      = r_pos;
        n_halted   = r_halted;
        n_seq      = r_seq;
        n_ts       = r_ts;
        n_len      = r_len;
        n_exp      = r_exp;
        n_crc      = r_crc;
        n_good     = r_good;
        n_fail     = r_fail;
        n_bytes    = r_bytes;
        len_err    = 1'b0;
        push_good  = 1'b0;
        o_q_push   = 1'b0;
        o_wr_en    = 1'b0;
        cmd_status = ST_PAYLOAD;
        if (accept) begin
            if (r_halted) begin
                if (i_item.end_of_stream) begin
                    n_halted = 1'b0;
                    n_pos    = '0;
                end
            end else if (r_pos < POS_W'(HEADER_BYTES)) begin
                if (r_pos < POS_W'(SEQ_END)) begin
                    n_seq = {i_item.data_byte, r_seq[63:8]};
                end else if (r_pos < POS_W'(TS_END)) begin
                    n_ts = {i_item.data_byte, r_ts[63:8]};
                end else if (r_pos < POS_W'(LEN_END)) begin
                    n_len = {i_item.data_byte, r_len[31:8]};
                end else if (r_pos < POS_W'(CRC_END)) begin
                    n_exp = {i_item.data_byte, r_exp[31:8]};
                end
                n_pos = np;
                if (np == POS_W'(HEADER_BYTES)) begin
                    if (n_len != 32'(PAYLOAD_BYTES)) begin
                        len_err    = 1'b1;
                        n_fail     = sat_inc32(r_fail);
                        o_q_push   = 1'b1;
                        cmd_status = ST_LEN_ERR;
                        n_pos      = '0;
                        n_halted   = !i_item.end_of_stream;
                    end else begin
                        n_crc = '1;
                    end
                end
            end else begin
                o_wr_en = 1'b1;
                n_crc   = crc32_byte(r_crc, i_item.data_byte);
                n_pos   = np;
                if (np >= POS_W'(REC_BYTES)) begin
                    n_pos    = '0;
                    n_bytes  = bytes_sum[48] ? MAX48 : bytes_sum[47:0];
                    o_q_push = 1'b1;
                    if (~n_crc == r_exp) begin
                        push_good  = 1'b1;
                        n_good     = sat_inc32(r_good);
                        cmd_status = ST_PAYLOAD;
                    end else begin
                        n_fail     = sat_inc32(r_fail);
                        cmd_status = ST_CRC_ERR;
                    end
                end
            end
            if (i_item.end_of_stream && !r_halted && !len_err) begin
                if (n_pos >= POS_W'(HEADER_BYTES)) begin
                    n_fail     = sat_inc32(r_fail);
                    o_q_push   = 1'b1;
                    cmd_status = ST_TRUNC;
                end
                n_pos = '0;
            end
        end
        n_wbank = r_wbank ^ push_good;
        n_busy  = r_busy + 2'(push_good) - 2'(i_release);
    end

    always_comb begin
        o_cmd.status         = cmd_status;
        o_cmd.sequence_res   = n_seq;
        o_cmd.timestamp      = n_ts;
        o_cmd.good_records   = n_good;
        o_cmd.failed_records = n_fail;
        o_cmd.bytes_accepted = n_bytes;
        o_cmd.bank           = r_wbank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_halted <= 1'b0;
            r_seq    <= '0;
            r_ts     <= '0;
            r_len    <= '0;
            r_exp    <= '0;
            r_crc    <= '1;
            r_good   <= '0;
            r_fail   <= '0;
            r_bytes  <= '0;
            r_wbank  <= 1'b0;
            r_busy   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_halted <= n_halted;
            r_seq    <= n_seq;
            r_ts     <= n_ts;
            r_len    <= n_len;
            r_exp    <= n_exp;
            r_crc    <= n_crc;
            r_good   <= n_good;
            r_fail   <= n_fail;
            r_bytes  <= n_bytes;
            r_wbank  <= n_wbank;
            r_busy   <= n_busy;
        end
    end

endmodule

@@ design/crcd_back.sv @@
// Result sequencer: payload buffer, buffer read stage and output register.
module crcd_back #(
    parameter int PAYLOAD_BYTES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1):0] i_wr_addr,
    input  logic [7:0]            i_wr_data,
    input  crcd_pkg::t_cmd        i_head,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    output logic                  o_release,
    input  logic                  i_pop,
    output logic                  o_empty,
    output crcd_pkg::t_result     o_result
);
    import crcd_pkg::*;

    localparam int IDX_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int MEM_DEPTH = 2 << IDX_W;

    logic [7:0]       r_mem [0:MEM_DEPTH-1];
    logic [7:0]       r_rd_data;
    logic [IDX_W-1:0] r_idx;
    logic             r_a_valid;
    t_result          r_a_res;
    logic             r_b_valid;
    t_result          r_b_res;

    logic             b_load;
    logic             a_move;
    logic             a_load;
    logic             issue;
    logic             head_good;
    logic             is_last;
    t_result          a_res_in;

    assign b_load    = !r_b_valid || i_pop;
    assign a_move    = r_a_valid && b_load;
    assign a_load    = !r_a_valid || a_move;
    assign issue     = i_q_valid && a_load;
    assign head_good = (i_head.status == ST_PAYLOAD);
    assign is_last   = !head_good || (r_idx == IDX_W'(PAYLOAD_BYTES - 1));
    assign o_q_pop   = issue && is_last;
    assign o_release = issue && is_last && head_good;
    assign o_empty   = !r_b_valid;
    assign o_result  = r_b_res;

    always_comb begin
        a_res_in.status         = i_head.status;
        a_res_in.payload_byte   = '0;
        a_res_in.last_of_run    = is_last;
        a_res_in.sequence_res   = i_head.sequence_res;
        a_res_in.timestamp      = i_head.timestamp;
        a_res_in.good_records   = i_head.good_records;
        a_res_in.failed_records = i_head.failed_records;
        a_res_in.bytes_accepted = i_head.bytes_accepted;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{i_head.bank, r_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_res <= a_res_in;
        end
        if (a_move) begin
            r_b_res <= r_a_res;
            if (r_a_res.status == ST_PAYLOAD) begin
                r_b_res.payload_byte <= r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end
            if (a_load) begin
                r_a_valid <= issue;
            end
            if (b_load) begin
                r_b_valid <= a_move;
            end
        end
    end

endmodule

@@ design/crc_checked_record_deframer_core.sv @@
// Top level of the CRC-checked record deframer: parser, command queue and result sequencer.
//
//  channel   handshake          payload
//  -------   ----------------   ------------------------------
//  input     push / full        i_item   (data_byte, end_of_stream)
//  result    empty / pop        o_result (status .. bytes_accepted)
//
// One byte a cycle is taken while full is low; one result a cycle, while pop is held, leaves
// through a two-stage read/output pipe. full rises when the two-entry command queue is full,
// or in payload bytes while both payload banks still wait to be read out.
// A good record yields PAYLOAD_BYTES results, an error record one result.
// Reset is synchronous; the payload buffer needs no clearing, every entry is written first.
module crc_checked_record_deframer_core #(
    parameter int PAYLOAD_BYTES = 32,
    parameter int HEADER_BYTES  = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  crcd_pkg::t_in_item   i_item,
    output logic                 empty,
    input  logic                 pop,
    output crcd_pkg::t_result    o_result
);
    import crcd_pkg::*;

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_valid;
    t_cmd           q_cmd;
    t_cmd           q_head;
    logic           release_bank;
    logic           wr_en;
    logic [IDX_W:0] wr_addr;
    logic [7:0]     wr_data;

    crcd_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .i_q_full  (q_full),
        .i_release (release_bank),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_cmd     (q_cmd),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    crcd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    crcd_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_head    (q_head),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .o_release (release_bank),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("command pushed into a full queue");

    a_no_queue_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command popped from an empty queue");

    a_release_good_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        release_bank |-> (q_valid && q_head.status == ST_PAYLOAD))
        else $error("payload bank released without a good record");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty)
        else $error("result shown straight after reset");
`endif

endmodule
